>>> rtl/awp_pkg.sv
// ----------------------------------------------------------------------------
// awp_pkg
// Shared types, widths and angle tables for the arrowhead wing point block.
// ----------------------------------------------------------------------------
package awp_pkg;

   localparam int COORD_BITS    = 16;
   localparam int CORDIC_STAGES = 16;

   localparam int VW = COORD_BITS + 18;          // vectoring datapath
   localparam int ZW = 20;                       // Q6.14 angle, signed
   localparam int RW = 20;                       // rotation datapath
   localparam int HW = 17;                       // half angle, unsigned
   localparam int PW = 29;                       // length * sin/cos
   localparam int OW = ((COORD_BITS + 16 > PW + 1) ? COORD_BITS + 16 : PW + 1) + 1;
   localparam int SW = $clog2(CORDIC_STAGES);
   localparam int DW = ((4 * COORD_BITS + 7) / 8) * 8;

   localparam int ANG_PI      = 51472;
   localparam int ANG_TWO_PI  = 102944;
   localparam int ANG_HALF_PI = 25736;
   localparam int CORDIC_GAIN = 19899;
   localparam int DEG_CODES   = 128;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] ex;
      logic signed [COORD_BITS-1:0] ey;
      logic                         degen;
   } side_type;

   typedef struct packed {
      logic signed [VW-1:0] x;
      logic signed [VW-1:0] y;
      logic signed [ZW-1:0] z;
      side_type             side;
   } vec_type;

   typedef struct packed {
      logic signed [RW-1:0] x;
      logic signed [RW-1:0] y;
      logic signed [ZW-1:0] w;
      logic                 neg;
   } lane_type;

   typedef struct packed {
      lane_type  l1;
      lane_type  l2;
      side_type  side;
   } rot_type;

   function automatic logic signed [ZW-1:0] atan_q14(input logic [SW-1:0] i);
      logic signed [ZW-1:0] r;
      case (i)
         0:       r = ZW'(12868);
         1:       r = ZW'(7596);
         2:       r = ZW'(4014);
         3:       r = ZW'(2037);
         4:       r = ZW'(1023);
         5:       r = ZW'(512);
         6:       r = ZW'(256);
         7:       r = ZW'(128);
         8:       r = ZW'(64);
         9:       r = ZW'(32);
         10:      r = ZW'(16);
         11:      r = ZW'(8);
         12:      r = ZW'(4);
         13:      r = ZW'(2);
         14:      r = ZW'(1);
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic [DEG_CODES*HW-1:0] build_half();
      logic [DEG_CODES*HW-1:0] r;
      r = '0;
      for (int i = 0; i < DEG_CODES; i++) begin
         r[i*HW +: HW] = HW'((i * ANG_PI + 90) / 180);
      end
      return r;
   endfunction

   localparam logic [DEG_CODES*HW-1:0] HALF_TAB = build_half();

endpackage

>>> rtl/arrowhead_wing_points.sv
// ----------------------------------------------------------------------------
// arrowhead_wing_points
// Arrowhead wing points from line start and end, CORDIC cell chains.
// ----------------------------------------------------------------------------
// Takes one line per cycle while the chain is not stalled and returns both
// wing points of its arrowhead through one input register, a chain of
// vectoring cells for the line angle, one angle fold stage, a chain of
// rotation cells giving both wings' sine and cosine, one multiply stage and
// the output register. The whole chain stalls only when a result waits in the
// output register and the receiver is not ready.
// Start equal to end gives degenerate = 1 and both wings at the end point.
// Registers are to be written only while the block is empty; the block itself does not enforce it.
module arrowhead_wing_points (
   input  logic                   clock,
   input  logic                   reset,
   // start_x, start_y, end_x, end_y
   input  logic [awp_pkg::DW-1:0] req_tdata,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // wing1_x, wing1_y, wing2_x, wing2_y
   output logic [awp_pkg::DW-1:0] rsp_tdata,
   // degenerate, filled
   output logic [1:0]             rsp_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [3:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);

   localparam int CB = awp_pkg::COORD_BITS;
   localparam int N  = awp_pkg::CORDIC_STAGES;
   localparam int NV = 2 * N + 4;

   typedef enum logic [1:0] {
      REG_LENGTH = 2'd0,
      REG_HALF   = 2'd1,
      REG_FILL   = 2'd2
   } reg_type;

   logic [11:0] length_ff;
   logic [6:0]  half_deg_ff;
   logic        fill_ff;
   logic [NV-1:0] valid_ff;
   logic          en;

   // configuration
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff   <= 12'd10;
         half_deg_ff <= 7'd30;
         fill_ff     <= 1'b0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (reg_type'(csr_paddr[3:2]))
            REG_LENGTH: length_ff   <= csr_pwdata[11:0];
            REG_HALF:   half_deg_ff <= csr_pwdata[6:0];
            REG_FILL:   fill_ff     <= csr_pwdata[0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      case (reg_type'(csr_paddr[3:2]))
         REG_LENGTH: csr_prdata = {20'd0, length_ff};
         REG_HALF:   csr_prdata = {25'd0, half_deg_ff};
         REG_FILL:   csr_prdata = {31'd0, fill_ff};
         default:    csr_prdata = '0;
      endcase
   end

   // flow control
   assign en         = !valid_ff[NV-1] || rsp_tready;
   assign req_tready = en && !reset;
   assign rsp_tvalid = valid_ff[NV-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[NV-2:0], req_tvalid};
      end
   end

   // input stage
   logic signed [CB-1:0] sx, sy, ex, ey;
   logic signed [CB:0]   ux, uy;
   awp_pkg::vec_type     vec_in0, vec_ff0;
   awp_pkg::vec_type     vec_q [0:N];

   assign sx = req_tdata[0*CB +: CB];
   assign sy = req_tdata[1*CB +: CB];
   assign ex = req_tdata[2*CB +: CB];
   assign ey = req_tdata[3*CB +: CB];
   assign ux = {sx[CB-1], sx} - {ex[CB-1], ex};
   assign uy = {ey[CB-1], ey} - {sy[CB-1], sy};

   always_comb begin
      vec_in0.x          = awp_pkg::VW'(ux) <<< 14;
      vec_in0.y          = awp_pkg::VW'(uy) <<< 14;
      vec_in0.z          = '0;
      vec_in0.side.ex    = ex;
      vec_in0.side.ey    = ey;
      vec_in0.side.degen = (ux == '0) && (uy == '0);
      if (ux[CB]) begin
         vec_in0.x = -vec_in0.x;
         vec_in0.y = -vec_in0.y;
         vec_in0.z = awp_pkg::ZW'(awp_pkg::ANG_PI);
      end
   end

   always_ff @(posedge clock) begin
      if (en) vec_ff0 <= vec_in0;
   end

   assign vec_q[0] = vec_ff0;

   for (genvar i = 0; i < N; i++) begin : g_vec
      awp_vec_cell u_cell (
         .clock (clock),
         .en    (en),
         .shift (awp_pkg::SW'(i)),
         .d_in  (vec_q[i]),
         .d_out (vec_q[i+1])
      );
   end

   // wing angles, wrap and fold
   logic [awp_pkg::HW-1:0] half;
   awp_pkg::rot_type       rot_in0, rot_ff0;
   awp_pkg::rot_type       rot_q [0:N];

   assign half = awp_pkg::HALF_TAB[half_deg_ff * awp_pkg::HW +: awp_pkg::HW];

   function automatic awp_pkg::lane_type fold(input logic signed [awp_pkg::ZW-1:0] a);
      awp_pkg::lane_type    r;
      logic signed [awp_pkg::ZW-1:0] w;
      w = a;
      if (w >= awp_pkg::ZW'(awp_pkg::ANG_PI))
         w = w - awp_pkg::ZW'(awp_pkg::ANG_TWO_PI);
      else if (w < -awp_pkg::ZW'(awp_pkg::ANG_PI))
         w = w + awp_pkg::ZW'(awp_pkg::ANG_TWO_PI);
      r.neg = 1'b0;
      if (w > awp_pkg::ZW'(awp_pkg::ANG_HALF_PI)) begin
         w     = w - awp_pkg::ZW'(awp_pkg::ANG_PI);
         r.neg = 1'b1;
      end else if (w < -awp_pkg::ZW'(awp_pkg::ANG_HALF_PI)) begin
         w     = w + awp_pkg::ZW'(awp_pkg::ANG_PI);
         r.neg = 1'b1;
      end
      r.w = w;
      r.x = awp_pkg::RW'(awp_pkg::CORDIC_GAIN);
      r.y = '0;
      return r;
   endfunction

   always_comb begin
      rot_in0.l1   = fold(vec_q[N].z - $signed({3'b000, half}));
      rot_in0.l2   = fold(vec_q[N].z + $signed({3'b000, half}));
      rot_in0.side = vec_q[N].side;
   end

   always_ff @(posedge clock) begin
      if (en) rot_ff0 <= rot_in0;
   end

   assign rot_q[0] = rot_ff0;

   for (genvar i = 0; i < N; i++) begin : g_rot
      awp_rot_cell u_cell (
         .clock (clock),
         .en    (en),
         .shift (awp_pkg::SW'(i)),
         .d_in  (rot_q[i]),
         .d_out (rot_q[i+1])
      );
   end

   // sine/cosine saturation and products
   function automatic logic signed [15:0] sat16(input logic signed [awp_pkg::RW-1:0] v,
                                                input logic neg);
      logic signed [awp_pkg::RW-1:0] t;
      t = neg ? -v : v;
      if (t > awp_pkg::RW'(32767))       return 16'sd32767;
      else if (t < -awp_pkg::RW'(32768)) return -16'sd32768;
      else                               return t[15:0];
   endfunction

   logic signed [awp_pkg::PW-1:0] p1x_ff, p1y_ff, p2x_ff, p2y_ff;
   awp_pkg::side_type             side_ff;
   logic signed [12:0]            len_s;

   assign len_s = $signed({1'b0, length_ff});

   always_ff @(posedge clock) begin
      if (en) begin
         p1x_ff  <= len_s * sat16(rot_q[N].l1.x, rot_q[N].l1.neg);
         p1y_ff  <= len_s * sat16(rot_q[N].l1.y, rot_q[N].l1.neg);
         p2x_ff  <= len_s * sat16(rot_q[N].l2.x, rot_q[N].l2.neg);
         p2y_ff  <= len_s * sat16(rot_q[N].l2.y, rot_q[N].l2.neg);
         side_ff <= rot_q[N].side;
      end
   end

   // final offset, truncation toward zero, saturation
   function automatic logic signed [CB-1:0] place(input logic signed [CB-1:0] e,
                                                  input logic signed [awp_pkg::PW-1:0] p,
                                                  input logic sub);
      logic signed [awp_pkg::OW-1:0]    v;
      logic signed [awp_pkg::OW-16:0]   q;
      v = (awp_pkg::OW'(e) <<< 15);
      v = sub ? v - awp_pkg::OW'(p) : v + awp_pkg::OW'(p);
      q = v[awp_pkg::OW-1:15];
      if (v[awp_pkg::OW-1] && (v[14:0] != '0)) q = q + 1'b1;
      if (q > (awp_pkg::OW-15)'((1 << (CB - 1)) - 1))
         return {1'b0, {(CB-1){1'b1}}};
      else if (q < -(awp_pkg::OW-15)'(1 << (CB - 1)))
         return {1'b1, {(CB-1){1'b0}}};
      else
         return q[CB-1:0];
   endfunction

   logic signed [CB-1:0] w1x_ff, w1y_ff, w2x_ff, w2y_ff;
   logic                 degen_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         degen_ff <= side_ff.degen;
         if (side_ff.degen) begin
            w1x_ff <= side_ff.ex;
            w1y_ff <= side_ff.ey;
            w2x_ff <= side_ff.ex;
            w2y_ff <= side_ff.ey;
         end else begin
            w1x_ff <= place(side_ff.ex, p1x_ff, 1'b0);
            w1y_ff <= place(side_ff.ey, p1y_ff, 1'b1);
            w2x_ff <= place(side_ff.ex, p2x_ff, 1'b0);
            w2y_ff <= place(side_ff.ey, p2y_ff, 1'b1);
         end
      end
   end

   assign rsp_tdata = awp_pkg::DW'({w2y_ff, w2x_ff, w1y_ff, w1x_ff});
   assign rsp_tuser = {fill_ff, degen_ff};

endmodule

>>> rtl/awp_vec_cell.sv
// ----------------------------------------------------------------------------
// awp_vec_cell
// One vectoring micro-rotation; finds the line angle over the chain.
// ----------------------------------------------------------------------------
module awp_vec_cell (
   input  logic                   clock,
   input  logic                   en,
   input  logic [awp_pkg::SW-1:0] shift,
   input  awp_pkg::vec_type       d_in,
   output awp_pkg::vec_type       d_out
);

   awp_pkg::vec_type q_ff, q_in;

   always_comb begin
      q_in      = d_in;
      if (!d_in.y[awp_pkg::VW-1]) begin
         q_in.x = d_in.x + (d_in.y >>> shift);
         q_in.y = d_in.y - (d_in.x >>> shift);
         q_in.z = d_in.z + awp_pkg::atan_q14(shift);
      end else begin
         q_in.x = d_in.x - (d_in.y >>> shift);
         q_in.y = d_in.y + (d_in.x >>> shift);
         q_in.z = d_in.z - awp_pkg::atan_q14(shift);
      end
   end

   always_ff @(posedge clock) begin
      if (en) q_ff <= q_in;
   end

   assign d_out = q_ff;

endmodule

>>> rtl/awp_rot_cell.sv
// ----------------------------------------------------------------------------
// awp_rot_cell
// One rotation micro-step for both wings; builds cosine and sine.
// ----------------------------------------------------------------------------
module awp_rot_cell (
   input  logic                   clock,
   input  logic                   en,
   input  logic [awp_pkg::SW-1:0] shift,
   input  awp_pkg::rot_type       d_in,
   output awp_pkg::rot_type       d_out
);

   awp_pkg::rot_type q_ff, q_in;

   function automatic awp_pkg::lane_type step(input awp_pkg::lane_type a,
                                              input logic [awp_pkg::SW-1:0] s);
      awp_pkg::lane_type r;
      r = a;
      if (!a.w[awp_pkg::ZW-1]) begin
         r.x = a.x - (a.y >>> s);
         r.y = a.y + (a.x >>> s);
         r.w = a.w - awp_pkg::atan_q14(s);
      end else begin
         r.x = a.x + (a.y >>> s);
         r.y = a.y - (a.x >>> s);
         r.w = a.w + awp_pkg::atan_q14(s);
      end
      return r;
   endfunction

   always_comb begin
      q_in      = d_in;
      q_in.l1   = step(d_in.l1, shift);
      q_in.l2   = step(d_in.l2, shift);
   end

   always_ff @(posedge clock) begin
      if (en) q_ff <= q_in;
   end

   assign d_out = q_ff;

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Arrowhead wing point block: directed and random lines through a CORDIC
// predictor, APB register settings across their extremes, random gaps on both
// stream sides and one long output hold-off that fills the pipeline.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int        CB        = awp_pkg::COORD_BITS;
   localparam int        DW        = awp_pkg::DW;
   localparam logic [3:0] REG_LEN  = 4'd0;
   localparam logic [3:0] REG_HALF = 4'd4;
   localparam logic [3:0] REG_FILL = 4'd8;
   localparam int        LATENCY   = awp_pkg::CORDIC_STAGES * 2 + 4;
   localparam longint    MAX_CYCLES = 400000;

   typedef struct packed {
      logic signed [CB-1:0] w1x;
      logic signed [CB-1:0] w1y;
      logic signed [CB-1:0] w2x;
      logic signed [CB-1:0] w2y;
      logic                 degen;
      logic                 filled;
   } wings_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic [DW-1:0]   req_tdata = '0;
   logic            req_tvalid = 1'b0;
   logic            req_tready;
   logic [DW-1:0]   rsp_tdata;
   logic [1:0]      rsp_tuser;
   logic            rsp_tvalid;
   logic            rsp_tready = 1'b0;
   logic            csr_psel = 1'b0;
   logic            csr_penable = 1'b0;
   logic            csr_pwrite = 1'b0;
   logic [3:0]      csr_paddr = '0;
   logic [31:0]     csr_pwdata = '0;
   logic [31:0]     csr_prdata;
   logic            csr_pready;

   logic [11:0]     arrow_len = 12'd10;
   logic [6:0]      half_deg = 7'd30;
   logic            fill_on = 1'b0;

   wings_type       wings_due[$];
   int              mismatches = 0;
   longint          cycles = 0;
   bit              hold_off = 1'b0;

   arrowhead_wing_points i_dut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > MAX_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic longint shr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint atan_step(int i);
      longint t[15] = '{12868, 7596, 4014, 2037, 1023, 512, 256, 128,
                        64, 32, 16, 8, 4, 2, 1};
      return i < 15 ? t[i] : 0;
   endfunction

   function automatic longint line_angle(longint x, longint y);
      longint z, nx, ny;
      z = 0;
      if (x < 0) begin
         x = -x;
         y = -y;
         z = awp_pkg::ANG_PI;
      end
      for (int i = 0; i < awp_pkg::CORDIC_STAGES; i++) begin
         if (y >= 0) begin
            nx = x + shr(y, i);
            ny = y - shr(x, i);
            z += atan_step(i);
         end else begin
            nx = x - shr(y, i);
            ny = y + shr(x, i);
            z -= atan_step(i);
         end
         x = nx;
         y = ny;
      end
      return z;
   endfunction

   task automatic rotate(longint w, output longint c, output longint s);
      longint x, y, nx, ny;
      bit neg;
      x = awp_pkg::CORDIC_GAIN;
      y = 0;
      neg = 0;
      while (w >= awp_pkg::ANG_PI) w -= awp_pkg::ANG_TWO_PI;
      while (w < -awp_pkg::ANG_PI) w += awp_pkg::ANG_TWO_PI;
      if (w > awp_pkg::ANG_HALF_PI) begin
         w -= awp_pkg::ANG_PI;
         neg = 1;
      end else if (w < -awp_pkg::ANG_HALF_PI) begin
         w += awp_pkg::ANG_PI;
         neg = 1;
      end
      for (int i = 0; i < awp_pkg::CORDIC_STAGES; i++) begin
         if (w >= 0) begin
            nx = x - shr(y, i);
            ny = y + shr(x, i);
            w -= atan_step(i);
         end else begin
            nx = x + shr(y, i);
            ny = y - shr(x, i);
            w += atan_step(i);
         end
         x = nx;
         y = ny;
      end
      if (neg) begin
         x = -x;
         y = -y;
      end
      c = clip(x, -32768, 32767);
      s = clip(y, -32768, 32767);
   endtask

   task automatic wing_at(longint ex, longint ey, longint w,
                          output logic signed [CB-1:0] wx,
                          output logic signed [CB-1:0] wy);
      longint c, s, lo, hi;
      lo = -(longint'(1) << (CB - 1));
      hi = (longint'(1) << (CB - 1)) - 1;
      rotate(w, c, s);
      // SV integer division truncates toward zero, as wanted
      wx = CB'(clip((ex * 32768 + longint'(arrow_len) * c) / 32768, lo, hi));
      wy = CB'(clip((ey * 32768 - longint'(arrow_len) * s) / 32768, lo, hi));
   endtask

   task automatic predict_wings(logic signed [CB-1:0] sx, logic signed [CB-1:0] sy,
                                logic signed [CB-1:0] ex, logic signed [CB-1:0] ey);
      wings_type r;
      longint ux, uy, theta, half;
      ux = longint'(sx) - longint'(ex);
      uy = longint'(ey) - longint'(sy);
      r.w1x = ex;
      r.w1y = ey;
      r.w2x = ex;
      r.w2y = ey;
      r.degen = 1'b0;
      r.filled = fill_on;
      if (ux == 0 && uy == 0) begin
         r.degen = 1'b1;
      end else begin
         theta = line_angle(ux * 16384, uy * 16384);
         half = (longint'(half_deg) * awp_pkg::ANG_PI + 90) / 180;
         wing_at(ex, ey, theta - half, r.w1x, r.w1y);
         wing_at(ex, ey, theta + half, r.w2x, r.w2y);
      end
      wings_due.push_back(r);
   endtask

   task automatic idle_gap();
      int n;
      if ($urandom_range(99) < 60) return;
      n = ($urandom_range(99) < 90) ? $urandom_range(3, 1) : $urandom_range(40, 8);
      req_tvalid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   // leaves tvalid high so that the next transfer can follow at once
   task automatic send_line(logic signed [CB-1:0] sx, logic signed [CB-1:0] sy,
                            logic signed [CB-1:0] ex, logic signed [CB-1:0] ey);
      req_tdata <= {ey, ex, sy, sx};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_wings(sx, sy, ex, ey);
      @(negedge clock);
   endtask

   task automatic send_random(int n, bit gaps);
      logic signed [CB-1:0] sx, sy, ex, ey;
      for (int k = 0; k < n; k++) begin
         ex = CB'($urandom);
         ey = CB'($urandom);
         case ($urandom_range(4))
            0: begin
               sx = CB'($urandom);
               sy = CB'($urandom);
            end
            1: begin
               sx = ex;
               sy = ey;
            end
            2: begin
               sx = ex + CB'($signed($urandom_range(8)) - 4);
               sy = ey + CB'($signed($urandom_range(8)) - 4);
            end
            default: begin
               sx = ex + CB'($signed($urandom_range(800)) - 400);
               sy = ey + CB'($signed($urandom_range(800)) - 400);
            end
         endcase
         send_line(sx, sy, ex, ey);
         if (gaps) idle_gap();
      end
   endtask

   task automatic csr_write(logic [3:0] addr, logic [31:0] data);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (wings_due.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   task automatic set_regs(logic [11:0] len, logic [6:0] deg, logic fill);
      drain();
      csr_write(REG_LEN, 32'(len));
      csr_write(REG_HALF, 32'(deg));
      csr_write(REG_FILL, 32'(fill));
      arrow_len = len;
      half_deg = deg;
      fill_on = fill;
   endtask

   task automatic test_directed();
      logic signed [CB-1:0] mx, mn;
      mx = {1'b0, {(CB-1){1'b1}}};
      mn = {1'b1, {(CB-1){1'b0}}};
      send_line('0, '0, '0, '0);
      send_line(mx, mx, mx, mx);
      send_line(mn, mn, mn, mn);
      send_line(CB'(100), '0, '0, '0);
      send_line(CB'(-100), '0, '0, '0);
      send_line('0, CB'(100), '0, '0);
      send_line('0, CB'(-100), '0, '0);
      send_line(mn, mn, mx, mx);
      send_line(mx, mx, mn, mn);
      send_line(mn, mx, mx, mn);
      send_line(mx, mn, mn, mx);
      send_line(CB'(1), '0, '0, '0);
      send_line('0, '0, mx, '0);
      send_line('0, '0, '0, mn);
      send_line(CB'(-5), CB'(3), mx, mn);
      send_line(CB'(7), CB'(-9), mn, mx);
   endtask

   task automatic test_settings();
      set_regs(12'd4095, 7'd90, 1'b1);
      test_directed();
      send_random(60, 1);
      set_regs(12'd0, 7'd0, 1'b0);
      send_random(60, 1);
      set_regs(12'd4095, 7'd127, 1'b0);
      test_directed();
      send_random(60, 1);
      set_regs(12'd1, 7'd1, 1'b1);
      send_random(40, 1);
      set_regs(12'd2730, 7'd85, 1'b1);
      send_random(40, 1);
   endtask

   task automatic test_random();
      for (int p = 0; p < 6; p++) begin
         set_regs(12'($urandom), 7'($urandom_range(127)), 1'($urandom));
         send_random(110, 1'(p % 2));
      end
   endtask

   task automatic test_backpressure();
      hold_off = 1'b1;
      send_random(80, 0);
      hold_off = 1'b0;
   endtask

   // receiver ready with random gaps, or a long counted hold-off
   initial begin
      int n;
      @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (200) @(negedge clock);
            rsp_tready <= 1'b1;
            do @(negedge clock); while (hold_off);
         end else if ($urandom_range(99) < 25) begin
            n = ($urandom_range(99) < 90) ? $urandom_range(3, 1) : $urandom_range(40, 8);
            rsp_tready <= 1'b0;
            repeat (n) @(negedge clock);
            rsp_tready <= 1'b1;
            repeat ($urandom_range(6, 1)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(20, 1)) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      wings_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[0*CB +: CB], rsp_tdata[1*CB +: CB], rsp_tdata[2*CB +: CB],
                rsp_tdata[3*CB +: CB], rsp_tuser[0], rsp_tuser[1]};
         if (wings_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("tb: unexpected transfer %h", got);
         end else begin
            want = wings_due.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"tb: mismatch exp w1=(%0d,%0d) w2=(%0d,%0d) dg=%b f=%b",
                            " got w1=(%0d,%0d) w2=(%0d,%0d) dg=%b f=%b"},
                           want.w1x, want.w1y, want.w2x, want.w2y, want.degen,
                           want.filled, got.w1x, got.w1y, got.w2x, got.w2y,
                           got.degen, got.filled);
            end
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(negedge clock);
      test_directed();
      test_settings();
      test_backpressure();
      test_random();
      drain();
      if (mismatches == 0 && wings_due.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/awp_pkg.sv
rtl/awp_vec_cell.sv
rtl/awp_rot_cell.sv
rtl/arrowhead_wing_points.sv
dv/tb.sv
